[design/moi_pkg.sv]
`default_nettype none
package moi_pkg;
    localparam int ANGLE_BITS = 16;
    localparam int TURN_SHIFT = 48 - ANGLE_BITS;
    localparam int OUT_DOWN = (ANGLE_BITS > 16) ? ANGLE_BITS - 16 : 0;
    localparam int OUT_UP = (ANGLE_BITS < 16) ? 16 - ANGLE_BITS : 0;
    localparam int FRAC_BITS = ANGLE_BITS - 2;

    localparam logic [31:0] INV_TWO_PI = 32'd683565276;
    localparam logic [31:0] SIN_A1 = 32'd1686629713;
    localparam logic [31:0] SIN_A3 = 32'd693598669;
    localparam logic [31:0] SIN_A5 = 32'd85569306;
    localparam logic [31:0] SIN_A7 = 32'd5026993;
    localparam logic [31:0] SIN_A9 = 32'd172272;
    localparam logic [31:0] Q30_ONE = 32'd1073741824;

    localparam logic [15:0] FIRST_STEP_RESET = 16'd3277;
    localparam logic [19:0] MAX_STEP_RESET = 20'd65536;

    typedef enum logic {
        REG_FIRST_STEP = 1'b0,
        REG_MAX_STEP = 1'b1
    } t_reg_idx;

    // one command per sequencer step, each using the shared multiplier at most once
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,      // capture item, form dt and noisy sums
        OP_MID_A,     // rate*dt
        OP_MID_B,     // round, times 1/2pi
        OP_MID_C,     // round to units, form mid angle and u
        OP_SIN_U2,    // u2 = u*u >> 30
        OP_SIN_P9,
        OP_SIN_P7,
        OP_SIN_P5,
        OP_SIN_P3,
        OP_SIN_P1,    // t = (u*t) >> 30, clamp, store, swap to 1-u
        OP_ROT_A,     // vx*c
        OP_ROT_B,     // vy*s
        OP_ROT_C,     // vx*s
        OP_ROT_D,     // vy*c, then world y velocity
        OP_POS_X,     // wx*dt
        OP_POS_Y,     // wy*dt, x update
        OP_HEAD_A,    // y update, w_noisy*dt
        OP_HEAD_B,
        OP_HEAD_C     // heading update, result out
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_OUT
    } t_state;

    typedef struct packed {
        t_op  op;
        logic second; // second sine pass (argument 1-u)
    } t_cmd;
endpackage
`default_nettype wire

[design/midpoint_odometry_integrator_unit.sv]
// sequence: an accepted beat runs through load, 3 angle steps,
//   2 x 6 quarter-sine steps, 4 rotate steps, 2 position steps and 3 heading steps
// throughput: no new beat is taken until the result beat has gone out, set by the single shared multiplier
// reset (synchronous, active low): pose, heading, last stamp and first-sample flag cleared,
//   step registers back to 0.05 s first step and 1.0 s limit
`default_nettype none
module midpoint_odometry_integrator_unit (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // configuration write port
    input  wire logic                i_cfg_we,
    input  wire logic [0:0]          i_cfg_idx,
    input  wire logic [19:0]         i_cfg_data,
    // input beat
    input  wire logic                i_valid,
    output logic                     o_stall,
    input  wire logic [31:0]         i_time_stamp,
    input  wire logic signed [23:0]  i_vel_x,
    input  wire logic signed [23:0]  i_vel_y,
    input  wire logic signed [19:0]  i_turn_rate,
    input  wire logic signed [23:0]  i_noise_vx,
    input  wire logic signed [23:0]  i_noise_vy,
    input  wire logic signed [19:0]  i_noise_turn,
    // result beat
    output logic                     o_valid,
    input  wire logic                i_stall,
    output logic signed [31:0]       o_pose_x,
    output logic signed [31:0]       o_pose_y,
    output logic [15:0]              o_heading
);
    import moi_pkg::*;

    // sequencer command into the datapath
    t_cmd cmd;

    moi_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_cmd   (cmd)
    );

    // pose state, sine evaluation and integration
    moi_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_time_stamp (i_time_stamp),
        .i_vel_x      (i_vel_x),
        .i_vel_y      (i_vel_y),
        .i_turn_rate  (i_turn_rate),
        .i_noise_vx   (i_noise_vx),
        .i_noise_vy   (i_noise_vy),
        .i_noise_turn (i_noise_turn),
        .o_pose_x     (o_pose_x),
        .o_pose_y     (o_pose_y),
        .o_heading    (o_heading)
    );
endmodule
`default_nettype wire

[design/moi_ctrl.sv]
`default_nettype none
module moi_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_stall,
    output logic               o_valid,
    input  wire logic          i_stall,
    output moi_pkg::t_cmd      o_cmd
);
    import moi_pkg::*;

    t_state r_state, n_state;
    t_op r_op, n_op;
    logic r_second, n_second;

    always_comb begin
        n_state = r_state;
        n_op = r_op;
        n_second = r_second;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = ST_RUN;
                    n_op = OP_MID_A;
                    n_second = 1'b0;
                end
            end
            ST_RUN: begin
                case (r_op)
                    OP_SIN_P1: begin
                        if (!r_second) begin
                            n_second = 1'b1;
                            n_op = OP_SIN_U2;
                        end else begin
                            n_op = OP_ROT_A;
                        end
                    end
                    OP_HEAD_C: begin
                        n_state = ST_OUT;
                        n_op = OP_NONE;
                    end
                    default: n_op = t_op'(r_op + 5'd1);
                endcase
            end
            ST_OUT: begin
                if (!i_stall) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_stall = (r_state != ST_IDLE);
        o_valid = (r_state == ST_OUT);
        o_cmd.second = r_second;
        o_cmd.op = OP_NONE;
        case (r_state)
            ST_IDLE: o_cmd.op = i_valid ? OP_LOAD : OP_NONE;
            ST_RUN:  o_cmd.op = r_op;
            default: o_cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_op <= OP_NONE;
            r_second <= 1'b0;
        end else begin
            r_state <= n_state;
            r_op <= n_op;
            r_second <= n_second;
        end
    end
endmodule
`default_nettype wire

[design/moi_dpath.sv]
`default_nettype none
module moi_dpath (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire moi_pkg::t_cmd       i_cmd,
    input  wire logic                i_cfg_we,
    input  wire logic [0:0]          i_cfg_idx,
    input  wire logic [19:0]         i_cfg_data,
    input  wire logic [31:0]         i_time_stamp,
    input  wire logic signed [23:0]  i_vel_x,
    input  wire logic signed [23:0]  i_vel_y,
    input  wire logic signed [19:0]  i_turn_rate,
    input  wire logic signed [23:0]  i_noise_vx,
    input  wire logic signed [23:0]  i_noise_vy,
    input  wire logic signed [19:0]  i_noise_turn,
    output logic signed [31:0]       o_pose_x,
    output logic signed [31:0]       o_pose_y,
    output logic [15:0]              o_heading
);
    import moi_pkg::*;

    // configuration and architectural state
    logic [15:0] r_first_step;
    logic [19:0] r_max_step;
    logic signed [31:0] r_px, r_py;
    logic [ANGLE_BITS-1:0] r_head;
    logic [31:0] r_last;
    logic r_seen;

    // working registers
    logic [19:0] r_dt;
    logic signed [24:0] r_vx, r_vy;
    logic signed [19:0] r_wc;
    logic signed [20:0] r_wn;
    logic signed [63:0] r_prod;
    logic signed [39:0] r_rad;
    logic [30:0] r_u, r_u2, r_t;
    logic [30:0] r_sa, r_sb;
    logic [ANGLE_BITS-1:0] r_mid_q;
    logic signed [40:0] r_wx, r_wy;

    // shared multiplier, 33 x 33 signed (every operand fits in 33 bits)
    logic signed [32:0] m_a;
    logic signed [32:0] m_b;
    logic signed [65:0] m_p;
    assign m_p = m_a * m_b;

    function automatic logic signed [63:0] rsh(input logic signed [63:0] v, input int sh);
        logic [63:0] mag;
        logic [63:0] q;
        begin
            mag = v[63] ? 64'(-v) : 64'(v);
            q = (mag + (64'd1 << (sh - 1))) >> sh;
            rsh = v[63] ? -$signed(q) : $signed(q);
        end
    endfunction

    function automatic logic signed [31:0] sat(input logic signed [31:0] a,
                                                input logic signed [63:0] d);
        logic signed [64:0] s;
        begin
            s = 65'(a) + 65'(d);
            if (s > 65'sd2147483647) sat = 32'sh7fffffff;
            else if (s < -65'sd2147483648) sat = 32'sh80000000;
            else sat = s[31:0];
        end
    endfunction

    logic signed [63:0] rounded;
    logic [31:0] d_raw;
    logic [19:0] dt_n;
    logic signed [31:0] s_sig, c_sig;
    logic [1:0] quad;
    logic [ANGLE_BITS-1:0] mid;
    logic [30:0] t_clamp;
    logic signed [63:0] tmp_t;
    logic [63:0] poly_p;

    always_comb begin
        d_raw = i_time_stamp - r_last;
        if (!r_seen) dt_n = {4'd0, r_first_step};
        else if (d_raw > {12'd0, r_max_step}) dt_n = r_max_step;
        else dt_n = d_raw[19:0];
    end

    // signed sine/cosine from the two quarter-wave results
    always_comb begin
        quad = r_mid_q[ANGLE_BITS-1 -: 2];
        case (quad)
            2'd0: begin s_sig = $signed({1'b0, r_sa}); c_sig = $signed({1'b0, r_sb}); end
            2'd1: begin s_sig = $signed({1'b0, r_sb}); c_sig = -$signed({1'b0, r_sa}); end
            2'd2: begin s_sig = -$signed({1'b0, r_sa}); c_sig = -$signed({1'b0, r_sb}); end
            default: begin s_sig = -$signed({1'b0, r_sb}); c_sig = $signed({1'b0, r_sa}); end
        endcase
    end

    always_comb begin
        m_a = '0;
        m_b = '0;
        case (i_cmd.op)
            OP_MID_A:  begin m_a = 33'(r_wc); m_b = $signed({13'd0, r_dt}); end
            OP_MID_B:  begin m_a = 33'(r_rad); m_b = $signed({1'b0, INV_TWO_PI}); end
            OP_SIN_U2: begin m_a = $signed({2'b0, r_u}); m_b = $signed({2'b0, r_u}); end
            OP_SIN_P9: begin m_a = $signed({2'b0, r_u2}); m_b = $signed({1'b0, SIN_A9}); end
            OP_SIN_P7, OP_SIN_P5, OP_SIN_P3:
                       begin m_a = $signed({2'b0, r_u2}); m_b = $signed({2'b0, r_t}); end
            OP_SIN_P1: begin m_a = $signed({2'b0, r_u}); m_b = $signed({2'b0, r_t}); end
            OP_ROT_A:  begin m_a = 33'(r_vx); m_b = 33'(c_sig); end
            OP_ROT_B:  begin m_a = 33'(r_vy); m_b = 33'(s_sig); end
            OP_ROT_C:  begin m_a = 33'(r_vx); m_b = 33'(s_sig); end
            OP_ROT_D:  begin m_a = 33'(r_vy); m_b = 33'(c_sig); end
            OP_POS_X:  begin m_a = 33'(r_wx); m_b = $signed({13'd0, r_dt}); end
            OP_POS_Y:  begin m_a = 33'(r_wy); m_b = $signed({13'd0, r_dt}); end
            OP_HEAD_A: begin m_a = 33'(r_wn); m_b = $signed({13'd0, r_dt}); end
            OP_HEAD_B: begin m_a = 33'(r_rad); m_b = $signed({1'b0, INV_TWO_PI}); end
            default: ;
        endcase
    end

    // polynomial coefficient that the current product is subtracted from to form the next t
    logic [31:0] coef;
    always_comb begin
        case (i_cmd.op)
            OP_SIN_P9: coef = SIN_A7;
            OP_SIN_P7: coef = SIN_A5;
            OP_SIN_P5: coef = SIN_A3;
            OP_SIN_P3: coef = SIN_A1;
            default:   coef = '0;
        endcase
        poly_p = 64'(m_p) >> 30;
        tmp_t = $signed({32'd0, coef}) - $signed(poly_p);
        t_clamp = (poly_p > 64'(Q30_ONE)) ? Q30_ONE[30:0] : poly_p[30:0];
        rounded = rsh(r_prod, TURN_SHIFT + (i_cmd.op == OP_MID_C ? 1 : 0));
        mid = r_head + rounded[ANGLE_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_step <= FIRST_STEP_RESET;
            r_max_step <= MAX_STEP_RESET;
            r_px <= '0;
            r_py <= '0;
            r_head <= '0;
            r_last <= '0;
            r_seen <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (t_reg_idx'(i_cfg_idx))
                    REG_FIRST_STEP: r_first_step <= i_cfg_data[15:0];
                    default:        r_max_step <= i_cfg_data;
                endcase
            end
            case (i_cmd.op)
                OP_LOAD: begin
                    r_last <= i_time_stamp;
                    r_seen <= 1'b1;
                end
                OP_POS_Y: r_px <= sat(r_px, rsh(r_prod, 16));
                OP_HEAD_A: r_py <= sat(r_py, rsh(r_prod, 16));
                OP_HEAD_C: r_head <= r_head + rounded[ANGLE_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_dt <= dt_n;
                r_vx <= 25'(i_vel_x) + 25'(i_noise_vx);
                r_vy <= 25'(i_vel_y) + 25'(i_noise_vy);
                r_wc <= i_turn_rate;
                r_wn <= 21'(i_turn_rate) + 21'(i_noise_turn);
            end
            OP_MID_A, OP_HEAD_A: r_prod <= 64'(m_p);
            OP_MID_B, OP_HEAD_B: r_prod <= 64'(m_p);
            OP_MID_C: begin
                r_mid_q <= mid;
                r_u <= 31'({mid[FRAC_BITS-1:0], {(32 - ANGLE_BITS){1'b0}}});
            end
            OP_SIN_U2: r_u2 <= 31'(64'(m_p) >> 30);
            OP_SIN_P9, OP_SIN_P7, OP_SIN_P5, OP_SIN_P3: r_t <= tmp_t[30:0];
            OP_SIN_P1: begin
                if (!i_cmd.second) begin
                    r_sa <= t_clamp;
                    r_u <= 31'(Q30_ONE) - r_u;
                end else begin
                    r_sb <= t_clamp;
                end
            end
            OP_ROT_A, OP_ROT_C: r_prod <= 64'(m_p);
            OP_ROT_B: r_wx <= 41'(rsh(r_prod - 64'(m_p), 30));
            OP_ROT_D: r_wy <= 41'(rsh(r_prod + 64'(m_p), 30));
            OP_POS_X, OP_POS_Y: r_prod <= 64'(m_p);
            default: ;
        endcase
        if (i_cmd.op == OP_MID_A || i_cmd.op == OP_HEAD_A)
            r_rad <= 40'(rsh(64'(m_p), 16));
    end

    assign o_pose_x = r_px;
    assign o_pose_y = r_py;
    assign o_heading = 16'((32'(r_head) >> OUT_DOWN) << OUT_UP);
endmodule
`default_nettype wire
